// ----- design/mst_pkg.sv -----
// Package for the membership set table: shared constants, command codes
// and the controller/datapath command and status structs.
// No dependencies.
package mst_pkg;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int IN_VALUE_W      = 32;
    localparam int COUNT_OUT_W     = 5;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic start;   // request accepted: capture it, rewind the scan
        logic issue;   // read the slot at the scan address
        logic clear;   // post-reset clearing write at the scan address
        logic finish;  // write back and load the result register
    } t_ctrl_cmd;

    // datapath -> controller
    typedef struct packed {
        logic addr_last;  // scan address is at the last slot
        logic out_free;   // result register can take a new result
    } t_dp_status;

endpackage

// ----- design/membership_set_table_core.sv -----
// Top level of the membership set table: controller plus datapath.
// Depends on mst_pkg, mst_ctrl, mst_datapath.
//
//  channel   dir  handshake                 payload
//  --------  ---  ------------------------  ------------------------------------
//  request   in   i_in_valid / o_in_stall   i_cmd[1:0], i_value[31:0] signed
//  result    out  o_out_valid / i_out_stall o_success, o_full_refused,
//                                           o_member_count[4:0], o_is_empty
//
// Each request goes through the accept in ST_IDLE, a scan with one slot
// memory read per cycle over all CAPACITY slots, ST_DRAIN to compare the
// last read, and the write-back in ST_WB.
// After reset a clearing pass writes every slot while o_in_stall is high.
// A result waiting in the output register does not block the next
// request; write-back waits only if that register is still held.
module membership_set_table_core
    import mst_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [1:0]                   i_cmd,
    input  logic signed [IN_VALUE_W-1:0] i_value,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_success,
    output logic                         o_full_refused,
    output logic [COUNT_OUT_W-1:0]       o_member_count,
    output logic                         o_is_empty
);

    t_ctrl_cmd  w_cmd_bus;
    t_dp_status w_status;

    // sequencer: clear, scan, drain, write-back
    mst_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (w_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd_bus)
    );

    // slot memory, search, count and result register
    mst_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd_bus      (w_cmd_bus),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .i_out_stall    (i_out_stall),
        .o_status       (w_status),
        .o_out_valid    (o_out_valid),
        .o_success      (o_success),
        .o_full_refused (o_full_refused),
        .o_member_count (o_member_count),
        .o_is_empty     (o_is_empty)
    );

endmodule

// ----- design/mst_ctrl.sv -----
// Sequencer of the membership set table: clearing pass, slot scan,
// write-back. Depends on mst_pkg.
module mst_ctrl
    import mst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_dp_status i_status,
    output logic       o_in_stall,
    output t_ctrl_cmd  o_cmd
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WB
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.addr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = ST_SCAN;
                end
            end
            ST_SCAN: begin
                o_cmd.issue = 1'b1;
                if (i_status.addr_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_WB;  // last slot read is compared here
            end
            ST_WB: begin
                if (i_status.out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: n_state = ST_CLEAR;
        endcase
    end

    assign o_in_stall = (r_state != ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- design/mst_datapath.sv -----
// Datapath of the membership set table: slot memory, scan address,
// match/free search, member count and result register. Depends on mst_pkg.
module mst_datapath
    import mst_pkg::*;
#(
    parameter int CAPACITY    = CAPACITY_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_ctrl_cmd                    i_cmd_bus,
    input  logic [1:0]                   i_cmd,
    input  logic signed [IN_VALUE_W-1:0] i_value,
    input  logic                         i_out_stall,
    output t_dp_status                   o_status,
    output logic                         o_out_valid,
    output logic                         o_success,
    output logic                         o_full_refused,
    output logic [COUNT_OUT_W-1:0]       o_member_count,
    output logic                         o_is_empty
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int MW = VALUE_WIDTH + 1;  // {valid, value}

    logic [MW-1:0] mem [CAPACITY];

    logic [AW-1:0]          r_addr;
    logic [MW-1:0]          r_rd_data;
    logic                   r_rd_vld;
    logic [AW-1:0]          r_rd_idx;
    logic [1:0]             r_cmd;
    logic [VALUE_WIDTH-1:0] r_val;
    logic                   r_hit;
    logic [AW-1:0]          r_hit_idx;
    logic                   r_free;
    logic [AW-1:0]          r_free_idx;
    logic [CW-1:0]          r_count;
    logic [CW-1:0]          n_count;
    logic                   r_out_valid;
    logic                   r_res_success;
    logic                   r_res_refused;
    logic [CW-1:0]          r_res_count;

    logic [63:0]            w_ext;
    logic                   w_addr_last;
    logic                   w_ins_ok;
    logic                   w_rem_ok;
    logic                   w_refused;
    logic                   w_success;
    logic                   w_we;
    logic [AW-1:0]          w_wa;
    logic [MW-1:0]          w_wd;

    assign w_ext       = 64'(i_value);  // sign-extend, keep low bits
    assign w_addr_last = (r_addr == AW'(CAPACITY - 1));

    assign w_ins_ok  = (r_cmd == CMD_INSERT) && !r_hit && r_free;
    assign w_refused = (r_cmd == CMD_INSERT) && !r_hit && !r_free;
    assign w_rem_ok  = (r_cmd == CMD_REMOVE) && r_hit;
    assign w_success = w_ins_ok || w_rem_ok || ((r_cmd == CMD_LOOKUP) && r_hit);

    always_comb begin
        priority if (w_ins_ok) n_count = r_count + 1'b1;
        else if (w_rem_ok)     n_count = r_count - 1'b1;
        else                   n_count = r_count;
    end

    // single write port: clearing pass or write-back
    always_comb begin
        w_we = 1'b0;
        w_wa = r_addr;
        w_wd = '0;
        if (i_cmd_bus.clear) begin
            w_we = 1'b1;
        end else if (i_cmd_bus.finish && w_ins_ok) begin
            w_we = 1'b1;
            w_wa = r_free_idx;
            w_wd = {1'b1, r_val};
        end else if (i_cmd_bus.finish && w_rem_ok) begin
            w_we = 1'b1;
            w_wa = r_hit_idx;
            w_wd = {1'b0, r_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) mem[w_wa] <= w_wd;
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= mem[r_addr];
        r_rd_idx  <= r_addr;
    end

    // scan address and read-valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr   <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd_bus.issue;
            if (i_cmd_bus.start) begin
                r_addr <= '0;
            end else if (i_cmd_bus.clear || i_cmd_bus.issue) begin
                r_addr <= w_addr_last ? '0 : r_addr + 1'b1;
            end
        end
    end

    // request capture and first-match / first-free search
    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.start) begin
            r_cmd  <= i_cmd;
            r_val  <= w_ext[VALUE_WIDTH-1:0];
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_rd_vld) begin
            if (r_rd_data[MW-1] && (r_rd_data[VALUE_WIDTH-1:0] == r_val) && !r_hit) begin
                r_hit     <= 1'b1;
                r_hit_idx <= r_rd_idx;
            end
            if (!r_rd_data[MW-1] && !r_free) begin
                r_free     <= 1'b1;
                r_free_idx <= r_rd_idx;
            end
        end
    end

    // member count and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd_bus.finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd_bus.finish) begin
            r_res_success <= w_success;
            r_res_refused <= w_refused;
            r_res_count   <= n_count;
        end
    end

    assign o_status.addr_last = w_addr_last;
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_success      = r_res_success;
    assign o_full_refused = r_res_refused;
    assign o_member_count = COUNT_OUT_W'(r_res_count);
    assign o_is_empty     = (r_res_count == '0);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("member count above capacity");

    a_finish_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd_bus.finish |-> (!r_out_valid || !i_out_stall))
        else $error("result loaded over a pending result");

    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd_bus.finish && w_ins_ok) |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not raise the count");

    a_refused_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_success && o_full_refused))
        else $error("result both successful and refused");

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for membership_set_table_core: directed and random
// insert/remove/lookup requests checked against a behavioral set tracker.
// Depends on mst_pkg and the membership_set_table_core RTL.
module tb
    import mst_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // command code 3 is not defined by the block; it must act as a no-op
    localparam logic [1:0] CMD_UNUSED    = 2'd3;
    localparam int         REQ_CYCLES    = CAPACITY_DEF + 3;
    localparam int         WATCHDOG_MAX  = 4000;  // cycles with no handshake at all
    localparam int         HOLD_OFF_LEN  = 300;   // long result back-pressure
    localparam int         PHASE_ITEMS   = 220;
    localparam int         POOL_SIZE     = 20;

    typedef struct packed {
        logic                   success;
        logic                   full_refused;
        logic [COUNT_OUT_W-1:0] member_count;
        logic                   is_empty;
    } t_set_result;

    // Tracks the set contents and queues the result each accepted request
    // must produce; results come back strictly in request order.
    class membership_tracker;
        logic [IN_VALUE_W-1:0] slot_value [CAPACITY_DEF];
        bit                    slot_used  [CAPACITY_DEF];
        int unsigned           members;
        t_set_result           pending_results [$];
        int unsigned           mismatches;
        int unsigned           requests;
        int unsigned           results;
        int unsigned           refusals;
        int unsigned           hits;

        function new();
            members    = 0;
            mismatches = 0;
            requests   = 0;
            results    = 0;
            refusals   = 0;
            hits       = 0;
            foreach (slot_used[i]) slot_used[i] = 1'b0;
        endfunction

        function void apply_request(logic [1:0] cmd, logic [IN_VALUE_W-1:0] value);
            int          hit_idx;
            int          free_idx;
            t_set_result r;
            hit_idx  = -1;
            free_idx = -1;
            r        = '0;
            for (int i = 0; i < CAPACITY_DEF; i++) begin
                if (slot_used[i] && slot_value[i] == value && hit_idx < 0) hit_idx = i;
                if (!slot_used[i] && free_idx < 0) free_idx = i;
            end
            case (cmd)
                CMD_INSERT: begin
                    if (hit_idx < 0) begin
                        if (free_idx < 0) begin
                            r.full_refused = 1'b1;
                            refusals++;
                        end else begin
                            slot_value[free_idx] = value;
                            slot_used[free_idx]  = 1'b1;
                            members++;
                            r.success = 1'b1;
                        end
                    end
                end
                CMD_REMOVE: begin
                    if (hit_idx >= 0) begin
                        slot_used[hit_idx] = 1'b0;
                        members--;
                        r.success = 1'b1;
                    end
                end
                CMD_LOOKUP: begin
                    r.success = (hit_idx >= 0);
                end
                default: ;
            endcase
            if (r.success) hits++;
            r.member_count = members[COUNT_OUT_W-1:0];
            r.is_empty     = (members == 0);
            pending_results.push_back(r);
            requests++;
        endfunction

        function void compare_result(t_set_result got);
            t_set_result exp;
            results++;
            if (pending_results.size() == 0) begin
                mismatches++;
                $display("%0t: result with no request pending: success=%0b full=%0b",
                         $time, got.success, got.full_refused);
                $display("%0t:   count=%0d empty=%0b", $time, got.member_count,
                         got.is_empty);
                return;
            end
            exp = pending_results.pop_front();
            if (got.success !== exp.success || got.full_refused !== exp.full_refused ||
                got.member_count !== exp.member_count || got.is_empty !== exp.is_empty) begin
                mismatches++;
                $display("%0t: result %0d mismatch: expected success=%0b full=%0b",
                         $time, results, exp.success, exp.full_refused);
                $display("%0t:   expected count=%0d empty=%0b", $time, exp.member_count,
                         exp.is_empty);
                $display("%0t:   got success=%0b full=%0b count=%0d empty=%0b", $time,
                         got.success, got.full_refused, got.member_count, got.is_empty);
            end
        endfunction
    endclass

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_stall;
    logic [1:0]                   i_cmd;
    logic signed [IN_VALUE_W-1:0] i_value;
    logic                         o_out_valid;
    logic                         i_out_stall;
    logic                         o_success;
    logic                         o_full_refused;
    logic [COUNT_OUT_W-1:0]       o_member_count;
    logic                         o_is_empty;

    membership_tracker     tracker = new();
    int                    in_idle_pct   = 0;   // sender idle chance per cycle
    int                    out_stall_pct = 0;   // receiver stall chance per cycle
    int                    hold_left     = 0;   // long hold-off, counted down by the receiver
    int                    quiet_cycles  = 0;
    logic [IN_VALUE_W-1:0] value_pool [POOL_SIZE];

    membership_set_table_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_cmd          (i_cmd),
        .i_value        (i_value),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_success      (o_success),
        .o_full_refused (o_full_refused),
        .o_member_count (o_member_count),
        .o_is_empty     (o_is_empty)
    );

    // 2 ns clock
    initial i_clk = 1'b0;
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Receiver side: random stalls, or a long hold-off while hold_left runs.
    // A hold-off makes write-back wait on the held result, keeping o_in_stall high.
    initial begin
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                i_out_stall <= 1'b1;
                hold_left--;
            end else begin
                i_out_stall <= (out_stall_pct != 0) && ($urandom_range(99) < out_stall_pct);
            end
        end
    end

    // Result monitor: every accepted result goes to the tracker.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            tracker.compare_result({o_success, o_full_refused, o_member_count, o_is_empty});
    end

    // Watchdog: only cycles with no handshake on either side count.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_MAX) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // Offers one request starting at a falling edge and returns at the
    // falling edge after it is taken. Valid stays high across back-to-back
    // requests; it only drops for idle gaps.
    task automatic send_request(input logic [1:0] cmd, input logic [IN_VALUE_W-1:0] value);
        while (in_idle_pct != 0 && $urandom_range(99) < in_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_value    <= value;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        tracker.apply_request(cmd, value);
        @(negedge i_clk);
    endtask

    // New working set of values: a mix of extremes, small numbers of both
    // signs and full-range random patterns. More values than slots, so an
    // insert-heavy stretch runs the table full.
    task automatic refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            case ($urandom_range(3))
                0: value_pool[i] = $urandom;
                1: value_pool[i] = $urandom_range(20) - 10;
                2: begin
                    case ($urandom_range(3))
                        0: value_pool[i] = 32'h8000_0000;
                        1: value_pool[i] = 32'h7FFF_FFFF;
                        2: value_pool[i] = 32'h0000_0000;
                        default: value_pool[i] = 32'hFFFF_FFFF;
                    endcase
                end
                default: value_pool[i] = {1'($urandom_range(1)), 31'(i * 32'h0123_4567)};
            endcase
        end
    endtask

    // Random stretch: blocks of 40 requests, each block biased toward
    // filling, draining or neutral traffic on a pool of values.
    task automatic run_random_phase(input int count, input int idle_pct, input int stall_pct,
                                    input bit with_hold_off);
        int          ins_w;
        int          rem_w;
        int          pick;
        logic [1:0]  cmd;
        logic [IN_VALUE_W-1:0] value;
        in_idle_pct   = idle_pct;
        out_stall_pct = stall_pct;
        refresh_pool();
        ins_w = 40;
        rem_w = 30;
        for (int n = 0; n < count; n++) begin
            if (n % 40 == 0) begin
                case ($urandom_range(2))
                    0: begin ins_w = 65; rem_w = 15; end
                    1: begin ins_w = 15; rem_w = 65; end
                    default: begin ins_w = 40; rem_w = 30; end
                endcase
            end
            if (with_hold_off && n == 60) hold_left = HOLD_OFF_LEN;
            pick = $urandom_range(99);
            if (pick < ins_w)                  cmd = CMD_INSERT;
            else if (pick < ins_w + rem_w)     cmd = CMD_REMOVE;
            else if (pick < 96)                cmd = CMD_LOOKUP;
            else                               cmd = CMD_UNUSED;
            // mostly pool values so hits happen; some noise that is almost never present
            if ($urandom_range(9) == 0) value = $urandom;
            else                        value = value_pool[$urandom_range(POOL_SIZE - 1)];
            send_request(cmd, value);
        end
    endtask

    initial begin
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_cmd      = CMD_LOOKUP;
        i_value    = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: empty-table cases, extremes, duplicate insert, unused
        // command, then fill to capacity and insert twice more.
        send_request(CMD_LOOKUP, 32'd0);
        send_request(CMD_REMOVE, 32'd5);
        send_request(CMD_INSERT, 32'h8000_0000);
        send_request(CMD_INSERT, 32'h7FFF_FFFF);
        send_request(CMD_INSERT, 32'h0000_0000);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_INSERT, 32'hFFFF_FFFF);
        send_request(CMD_LOOKUP, 32'h8000_0000);
        send_request(CMD_UNUSED, 32'd7);
        send_request(CMD_REMOVE, 32'h0000_0000);
        send_request(CMD_LOOKUP, 32'h0000_0000);
        for (int i = 0; i < CAPACITY_DEF - 3; i++)
            send_request(CMD_INSERT, (i % 2) ? 32'hAAAA_AAA0 + i : 32'h5555_5550 + i);
        send_request(CMD_INSERT, 32'd555);          // table full: refused
        send_request(CMD_INSERT, 32'hFFFF_FFFF);    // table full, value present

        run_random_phase(PHASE_ITEMS, 0, 0, 1'b1);
        run_random_phase(PHASE_ITEMS, 55, 0, 1'b0);
        run_random_phase(PHASE_ITEMS, 0, 55, 1'b0);
        run_random_phase(PHASE_ITEMS, 24, 24, 1'b1);

        i_in_valid <= 1'b0;
        while (tracker.pending_results.size() != 0) @(posedge i_clk);
        // late stray results would still be caught by the monitor here
        repeat (2 * REQ_CYCLES + 4) @(posedge i_clk);

        $display("%0d requests sent, %0d results checked, %0d mismatches",
                 tracker.requests, tracker.results, tracker.mismatches);
        $display("%0d requests succeeded, %0d inserts refused on a full table",
                 tracker.hits, tracker.refusals);
        if (tracker.mismatches == 0 && tracker.pending_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- membership_set_table_core.f -----
design/mst_pkg.sv
design/mst_ctrl.sv
design/mst_datapath.sv
design/membership_set_table_core.sv
bench/tb.sv
